>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/md5_pkg.sv
// ---------------------------------------------------------------------------
// MD5 digest unit package
// Round constants, shift amounts, word selection codes and the command and
// status bundles that join the controller and the datapath.
// ---------------------------------------------------------------------------
package md5_pkg;

   localparam logic [31:0] IV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   localparam logic [3:0] LAST_SLOT = 4'd15;
   localparam logic [3:0] LEN_SLOT  = 4'd14;
   localparam logic [1:0] LAST_IDX  = 2'd3;
   localparam logic [2:0] FULL_BYTES = 3'd4;

   typedef enum logic [2:0] {
      WSEL_FULL,
      WSEL_TAIL,
      WSEL_MARK,
      WSEL_ZERO,
      WSEL_LEN_LO,
      WSEL_LEN_HI
   } wsel_type;

   typedef struct packed {
      logic       put;
      wsel_type   wsel;
      logic       len_en;
      logic       load;
      logic       step;
      logic       fold;
      logic       capture;
      logic [1:0] out_sel;
   } cmd_type;

   typedef struct packed {
      logic [3:0] pos;
      logic       round_last;
   } status_type;

   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] lo;
      logic [3:0] idx;
      lo = r[3:0];
      case (r[5:4])
         2'd0: idx = lo;
         2'd1: idx = 4'((lo << 2) + lo + 4'd1);
         2'd2: idx = 4'((lo << 1) + lo + 4'd5);
         default: idx = 4'((lo << 3) - lo);
      endcase
      return idx;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] t;
      t = {v, v} << s;
      return t[63:32];
   endfunction

endpackage

>>> design/md5_datapath.sv
// ---------------------------------------------------------------------------
// MD5 datapath
// Block word store, chaining state, round registers, bit length counter and
// the digest output buffer, all driven by controller commands.
// ---------------------------------------------------------------------------
module md5_datapath (
   input  logic                clock,
   input  logic                reset,
   input  md5_pkg::cmd_type    cmd,
   input  logic [31:0]         msg_word,
   input  logic [2:0]          byte_count,
   input  logic                last_word,
   output md5_pkg::status_type status,
   output logic [31:0]         digest_word
);

   logic [31:0] chain_ff [4];
   logic [31:0] blk_ff [16];
   logic [31:0] obuf_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] kw_ff, kw_in;
   logic [60:0] len_ff;
   logic [3:0]  pos_ff;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  cnt;
   logic [31:0] tail_word, put_word;
   logic [31:0] f_val, sum_val, b_new;

   always_comb begin
      cnt = (byte_count > md5_pkg::FULL_BYTES) ? md5_pkg::FULL_BYTES : byte_count;
      case (cnt)
         3'd0: tail_word = 32'h0000_0080;
         3'd1: tail_word = {16'h0000, 8'h80, msg_word[7:0]};
         3'd2: tail_word = {8'h00, 8'h80, msg_word[15:0]};
         3'd3: tail_word = {8'h80, msg_word[23:0]};
         default: tail_word = msg_word;
      endcase
      case (cmd.wsel)
         md5_pkg::WSEL_FULL:   put_word = msg_word;
         md5_pkg::WSEL_TAIL:   put_word = tail_word;
         md5_pkg::WSEL_MARK:   put_word = 32'h0000_0080;
         md5_pkg::WSEL_LEN_LO: put_word = {len_ff[28:0], 3'b000};
         md5_pkg::WSEL_LEN_HI: put_word = len_ff[60:29];
         default:              put_word = 32'h0000_0000;
      endcase
   end

   always_comb begin
      rnd_in = cmd.load ? 6'd0 : 6'(rnd_ff + 6'd1);
      kw_in  = md5_pkg::ROUND_K[rnd_in] + blk_ff[md5_pkg::msg_index(rnd_in)];
      case (rnd_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum_val = a_ff + f_val + kw_ff;
      b_new   = b_ff + md5_pkg::rotl(sum_val, md5_pkg::ROT_AMT[{rnd_ff[5:4], rnd_ff[1:0]}]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            chain_ff[i] <= md5_pkg::IV[i];
         end
         len_ff <= '0;
         pos_ff <= '0;
         rnd_ff <= '0;
      end else begin
         if (cmd.put) begin
            pos_ff <= pos_ff + 4'd1;
         end
         if (cmd.len_en) begin
            len_ff <= len_ff + (last_word ? 61'(cnt) : 61'(md5_pkg::FULL_BYTES));
         end
         if (cmd.load || cmd.step) begin
            rnd_ff <= rnd_in;
         end
         if (cmd.fold) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
         if (cmd.capture) begin
            for (int i = 0; i < 4; i++) begin
               chain_ff[i] <= md5_pkg::IV[i];
            end
            len_ff <= '0;
            pos_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         blk_ff[pos_ff] <= put_word;
      end
      if (cmd.load) begin
         a_ff  <= chain_ff[0];
         b_ff  <= chain_ff[1];
         c_ff  <= chain_ff[2];
         d_ff  <= chain_ff[3];
         kw_ff <= kw_in;
      end else if (cmd.step) begin
         a_ff  <= d_ff;
         b_ff  <= b_new;
         c_ff  <= b_ff;
         d_ff  <= c_ff;
         kw_ff <= kw_in;
      end
      if (cmd.capture) begin
         for (int i = 0; i < 4; i++) begin
            obuf_ff[i] <= chain_ff[i];
         end
      end
   end

   assign status.pos        = pos_ff;
   assign status.round_last = (rnd_ff == 6'd63);
   assign digest_word       = obuf_ff[cmd.out_sel];

endmodule

>>> design/md5_controller.sv
// ---------------------------------------------------------------------------
// MD5 controller
// Sequences word insertion, padding, the 64 compression rounds and the
// four-beat digest output.
// ---------------------------------------------------------------------------
module md5_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_byte_count,
   input  logic                req_last_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_digest_index,
   output logic                rsp_digest_last,
   input  md5_pkg::status_type status,
   output md5_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_MSG,
      PH_MARK,
      PH_ZERO,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_DONE
   } phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_last_slot;

   assign at_last_slot = (status.pos == md5_pkg::LAST_SLOT);

   always_comb begin
      cmd         = '0;
      cmd.wsel    = md5_pkg::WSEL_ZERO;
      cmd.out_sel = idx_ff;
      state_in    = state_ff;
      phase_in    = phase_ff;
      req_ready   = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.put    = 1'b1;
               cmd.len_en = 1'b1;
               if (req_last_word) begin
                  cmd.wsel = md5_pkg::WSEL_TAIL;
                  phase_in = (req_byte_count >= md5_pkg::FULL_BYTES) ? PH_MARK : PH_ZERO;
                  state_in = ST_PUT;
               end else begin
                  cmd.wsel = md5_pkg::WSEL_FULL;
                  phase_in = PH_MSG;
               end
               if (at_last_slot) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PUT: begin
            case (phase_ff)
               PH_MARK: begin
                  cmd.put  = 1'b1;
                  cmd.wsel = md5_pkg::WSEL_MARK;
                  phase_in = PH_ZERO;
               end
               PH_ZERO: begin
                  if (status.pos == md5_pkg::LEN_SLOT) begin
                     phase_in = PH_LEN_LO;
                  end else begin
                     cmd.put = 1'b1;
                  end
               end
               PH_LEN_LO: begin
                  cmd.put  = 1'b1;
                  cmd.wsel = md5_pkg::WSEL_LEN_LO;
                  phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  cmd.put  = 1'b1;
                  cmd.wsel = md5_pkg::WSEL_LEN_HI;
                  phase_in = PH_DONE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
            if (cmd.put && at_last_slot) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.step = 1'b1;
            if (status.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            case (phase_ff)
               PH_MSG:  state_in = ST_IDLE;
               PH_DONE: state_in = ST_EMIT;
               default: state_in = ST_PUT;
            endcase
         end
         ST_EMIT: begin
            if (!busy_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (cmd.capture) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (busy_ff && rsp_ready) begin
         if (idx_ff == md5_pkg::LAST_IDX) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MSG;
         busy_ff  <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid        = busy_ff;
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = (idx_ff == md5_pkg::LAST_IDX);

endmodule

>>> design/md5_message_digest_unit.sv
// A word that does not fill a block is only stored; a word that fills one
// also starts a compression (state load, 64 rounds, chaining add).
// A last word pads the block and runs one or two compressions,
// then the digest leaves as four beats from an output buffer.
// Words are accepted only while idle, so input is held off during padding and compression.
// Reset is synchronous and active high; it restores the initial chaining state.
// ---------------------------------------------------------------------------
// MD5 message digest unit
// Streams message words in, compresses 512-bit blocks, pads the message and
// returns the 128-bit digest as four words.
// ---------------------------------------------------------------------------
module md5_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_digest_index,
   output logic        rsp_digest_last
);

   md5_pkg::cmd_type    cmd;
   md5_pkg::status_type status;

   md5_controller u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_count   (req_byte_count),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last),
      .status           (status),
      .cmd              (cmd)
   );

   md5_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_word    (req_message_word),
      .byte_count  (req_byte_count),
      .last_word   (req_last_word),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

endmodule

>>> design/md5_checker.sv
// ---------------------------------------------------------------------------
// MD5 digest unit checker
// Port-level checks on the digest output sequence.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module md5_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [1:0]  rsp_digest_index,
   input logic        rsp_digest_last
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_digest_index))
   `ASSERT_SAME(a_last_flag, clock, reset, rsp_valid, rsp_digest_last == (rsp_digest_index == 2'd3))
   `ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && rsp_ready && !rsp_digest_last, rsp_valid && (rsp_digest_index == $past(rsp_digest_index) + 2'd1))
   `ASSERT_SAME(a_first_index, clock, reset, $rose(rsp_valid), rsp_digest_index == 2'd0)

endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (.*);
